// File: rtl/three_channel_wavetable_sound_chip_unit_assert.svh
// Assertion macros for the wavetable sound unit
`ifndef THREE_CHANNEL_WAVETABLE_SOUND_CHIP_UNIT_ASSERT_SVH
`define THREE_CHANNEL_WAVETABLE_SOUND_CHIP_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define TWS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset
`define TWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/tws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

    localparam int CHANNELS_DEF   = 3;
    localparam int WAVE_STEPS     = 64;
    localparam int PHASE_W        = 6;
    localparam int RATE_W         = 17;
    localparam int FREQ_W         = 16;
    localparam int PERIOD_W       = 16;
    localparam int REGS           = 16;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        WAVE_SQUARE = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_NOISE4 = 2'd2,
        WAVE_NOISE1 = 2'd3
    } wave_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

    localparam logic [1:0] VOL_REG = 2'd3;

    // Queue entry between front and back
    typedef struct packed {
        mode_t      mode;
        logic [3:0] address;
        logic [7:0] write_data;
    } op_t;

    // Noise pattern: 7-bit LFSR x^7+x^6+1, five steps per entry, low 5 bits
    function automatic logic [4:0] noise_rom(input logic [PHASE_W-1:0] idx);
        logic [6:0] lfsr;
        logic [4:0] val;
        lfsr = 7'd1;
        val = 5'd0;
        for (int i = 0; i < WAVE_STEPS; i++) begin
            for (int k = 0; k < 5; k++) begin
                lfsr = {lfsr[5:0], lfsr[6] ^ lfsr[5]};
            end
            if (i == int'(idx)) begin
                val = lfsr[4:0];
            end
        end
        return val;
    endfunction

    // Wave value for a wave id at a phase
    function automatic logic [7:0] wave_value(input logic [7:0] id,
                                              input logic [PHASE_W-1:0] phase);
        logic [PHASE_W-1:0] duty;
        logic [PHASE_W-1:0] step;
        logic [4:0]         nz;
        logic [7:0]         v;
        duty = id[5:0];
        step = (phase < duty) ? phase : phase - duty;
        nz = noise_rom(step);
        case (wave_kind_t'(id[7:6]))
            WAVE_SQUARE: v = step[5] ? 8'hFF : 8'h00;
            WAVE_TRI:    v = step[5] ? {3'b000, step[4:0]} : 8'd32 - {3'b000, step[4:0]};
            WAVE_NOISE4: v = {nz[3:0], 4'h0};
            default:     v = nz[4] ? 8'hFF : 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tws_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tws_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_mode,
    input  wire logic [3:0]       s_address,
    input  wire logic [7:0]       s_write_data,
    output tws_pkg::op_t          q_data,
    output logic                  q_valid,
    input  wire logic             q_ready
);
    // Two-entry queue
    tws_pkg::op_t mem_reg [2];
    logic [0:0]   wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rp_reg];

    // Store classified item
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= '{mode: tws_pkg::mode_t'(s_mode),
                                 address: s_address, write_data: s_write_data};
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/tws_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tws_back #(
    parameter int CHANNELS = tws_pkg::CHANNELS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [tws_pkg::RATE_W-1:0] cfg_wdata,
    input  wire tws_pkg::op_t               q_data,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_sample,
    output logic [7:0]                      m_read_data
);
    localparam int RW = tws_pkg::RATE_W;
    localparam int DIV_CNT_W = $clog2(RW + 1);

    tws_pkg::back_state_t state_reg, state_next;

    logic [RW-1:0]  rate_reg;
    logic [7:0]     rf_reg [tws_pkg::REGS];
    logic [7:0]     wsel_reg [CHANNELS];
    logic [7:0]     vol_reg [CHANNELS];
    logic [15:0]    per_reg [CHANNELS];
    logic [15:0]    cd_reg [CHANNELS];
    logic [5:0]     ph_reg [CHANNELS];

    // Divider state
    logic [RW-1:0]  quo_reg;
    logic [16:0]    rem_reg;
    logic [15:0]    div_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [1:0]     dch_reg;

    logic [7:0]     smp_reg, rd_reg;
    logic           out_full_reg;

    logic           take;
    logic [15:0]    freq;
    logic [1:0]     ch;
    logic           commit;
    logic [7:0]     mix;
    logic [16:0]    rem_sh;
    logic [RW-7:0]  pq;

    assign ch      = q_data.address[3:2];
    assign freq    = {rf_reg[{ch, 2'd1}], rf_reg[{ch, 2'd0}]};
    assign q_ready = (state_reg == tws_pkg::ST_IDLE) && !out_full_reg;
    assign take    = q_valid && q_ready;
    assign commit  = (q_data.mode == tws_pkg::MODE_WRITE) && (q_data.address[1:0] == tws_pkg::VOL_REG)
                     && (int'(ch) < CHANNELS);

    // Mix using current phases after step
    always_comb begin
        logic [5:0]  nph;
        logic [15:0] prod;
        mix = 8'd0;
        for (int c = 0; c < CHANNELS; c++) begin
            nph = ph_reg[c];
            if (per_reg[c] != 16'd0 && cd_reg[c] <= 16'd1) nph = ph_reg[c] + 6'd1;
            prod = tws_pkg::wave_value(wsel_reg[c], nph) * vol_reg[c];
            mix = mix + prod[15:8];
        end
    end

    assign rem_sh = {rem_reg[15:0], quo_reg[RW-1]};
    assign pq     = quo_reg[RW-1:6];

    // Sequence commit divide
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tws_pkg::ST_IDLE: if (take && commit && freq != 16'd0) state_next = tws_pkg::ST_DIV;
            tws_pkg::ST_DIV:  if (dcnt_reg == DIV_CNT_W'(RW - 1)) state_next = tws_pkg::ST_DONE;
            tws_pkg::ST_DONE: state_next = tws_pkg::ST_IDLE;
            default:          state_next = tws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tws_pkg::ST_IDLE;
            rate_reg     <= tws_pkg::RATE_RESET;
            out_full_reg <= 1'b0;
            for (int i = 0; i < tws_pkg::REGS; i++) rf_reg[i] <= 8'd0;
            for (int c = 0; c < CHANNELS; c++) begin
                wsel_reg[c] <= 8'd0;
                vol_reg[c]  <= 8'd0;
                per_reg[c]  <= 16'd0;
                cd_reg[c]   <= 16'd1;
                ph_reg[c]   <= 6'd0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) rate_reg <= cfg_wdata;
            if (m_valid && m_ready) out_full_reg <= 1'b0;
            if (take) begin
                out_full_reg <= 1'b1;
                smp_reg <= (q_data.mode == tws_pkg::MODE_TICK) ? mix : 8'd0;
                rd_reg  <= (q_data.mode == tws_pkg::MODE_READ) ? rf_reg[q_data.address] : 8'd0;
                unique case (q_data.mode)
                    tws_pkg::MODE_TICK: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (per_reg[c] != 16'd0) begin
                                if (cd_reg[c] <= 16'd1) begin
                                    ph_reg[c] <= ph_reg[c] + 6'd1;
                                    cd_reg[c] <= per_reg[c];
                                end else begin
                                    cd_reg[c] <= cd_reg[c] - 16'd1;
                                end
                            end
                        end
                    end
                    tws_pkg::MODE_WRITE: begin
                        rf_reg[q_data.address] <= q_data.write_data;
                        if (commit) begin
                            wsel_reg[ch] <= rf_reg[{ch, 2'd2}];
                            vol_reg[ch]  <= q_data.write_data;
                            if (freq == 16'd0) per_reg[ch] <= 16'd0;
                        end
                    end
                    default: ;
                endcase
                // Start restoring divide
                quo_reg  <= rate_reg;
                rem_reg  <= 17'd0;
                div_reg  <= freq;
                dcnt_reg <= '0;
                dch_reg  <= ch;
            end
            // One quotient bit per cycle
            if (state_reg == tws_pkg::ST_DIV) begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (rem_sh >= {1'b0, div_reg}) begin
                    rem_reg <= rem_sh - {1'b0, div_reg};
                    quo_reg <= {quo_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[RW-2:0], 1'b0};
                end
            end
            // Clamp and load period
            if (state_reg == tws_pkg::ST_DONE) begin
                per_reg[dch_reg] <= (pq == '0) ? 16'd1 : 16'(pq);
            end
        end
    end

    assign m_valid     = out_full_reg;
    assign m_sample    = smp_reg;
    assign m_read_data = rd_reg;
endmodule
`default_nettype wire

// File: rtl/three_channel_wavetable_sound_chip_unit.sv
// An accepted item passes through the two-entry queue and is then taken by the back end,
// which registers its result; results are held one at a time, so the back end takes no item while one waits.
// A commit with nonzero frequency holds the back end through the radix-2 divider (ST_DIV)
// and the period load (ST_DONE), so the item after it is taken only once both are done.
// Reset: synchronous active-low aresetn clears registers, channels and queue;
// the sample rate (rate_reg) returns to 44100.
`timescale 1ns / 1ps
`default_nettype none
`include "three_channel_wavetable_sound_chip_unit_assert.svh"
module three_channel_wavetable_sound_chip_unit #(
    parameter int CHANNELS = tws_pkg::CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [3:0]  s_address,
    input  wire logic [7:0]  s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_sample,
    output logic [7:0]       m_read_data
);
    tws_pkg::op_t q_data;
    logic         q_valid, q_ready;

    tws_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_address, .s_write_data,
        .q_data, .q_valid, .q_ready
    );

    tws_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .q_data, .q_valid, .q_ready,
        .m_valid, .m_ready, .m_sample, .m_read_data
    );

    `TWS_ASSERT_IMPL(a_out_excl, aclk, aresetn, m_valid, (m_sample == 8'd0) || (m_read_data == 8'd0))
    `TWS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample))
    `TWS_ASSERT_IMPL(a_no_take_full, aclk, aresetn, m_valid && !m_ready, !q_ready)
endmodule
`default_nettype wire
